>>> sv/assert_macros.svh
// Assertion macros shared by the stream parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ISP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define ISP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/isp_pkg.sv
// Shared types, constants and helper functions of the item record stream parser.
`default_nettype none

package isp_pkg;

   // Width of the sprite count arithmetic.
   localparam int COUNT_WIDTH = 24;
   // Width of the count fields on the result port.
   localparam int OUT_CNT_W   = 24;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [15:0] FIRST_ITEM   = 16'd100;
   localparam logic [3:0]  HEADER_BYTES = 4'd12;
   localparam logic [3:0]  GEOM_BYTES   = 4'd7;

   // Option codes.
   localparam logic [7:0] OPT_END       = 8'hFF;
   localparam logic [7:0] OPT_LAST      = 8'h1F;
   localparam logic [7:0] OPT_GROUND    = 8'h00;
   localparam logic [7:0] OPT_CONTAINER = 8'h04;
   localparam logic [7:0] OPT_WRITEABLE = 8'h09;
   localparam logic [7:0] OPT_WORD_0A   = 8'h0A;
   localparam logic [7:0] OPT_FLUID     = 8'h0B;
   localparam logic [7:0] OPT_SPLASH    = 8'h0C;
   localparam logic [7:0] OPT_DWORD_16  = 8'h16;
   localparam logic [7:0] OPT_DWORD_19  = 8'h19;
   localparam logic [7:0] OPT_WORD_1A   = 8'h1A;
   localparam logic [7:0] OPT_WORD_1D   = 8'h1D;
   localparam logic [7:0] OPT_WORD_1E   = 8'h1E;

   // Code reported with an error when the sprite count overflows.
   localparam logic [7:0] ERR_COUNT_OVERFLOW = 8'hFF;

   typedef enum logic [2:0] {
      EV_HEADER,
      EV_OPTION,
      EV_GEOM,
      EV_SPRITE,
      EV_ERROR
   } event_type;

   typedef enum logic [2:0] {
      GRP_NONE,
      GRP_GROUND,
      GRP_CONTAINER,
      GRP_FLUID,
      GRP_SPLASH,
      GRP_WRITEABLE
   } group_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      event_type            event_res;
      logic [15:0]          item_id;
      logic [7:0]           code;
      logic [31:0]          value;
      logic [15:0]          value_high;
      group_type            item_group;
      logic [OUT_CNT_W-1:0] sprite_count;
      logic [OUT_CNT_W-1:0] sprite_index;
      logic [15:0]          sprite_id;
      logic                 sprite_keep;
      logic                 last_of_item;
   } rsp_type;

   // Number of payload bytes behind a known option code.
   function automatic logic [2:0] payload_len(input logic [7:0] c);
      case (c) inside
         OPT_GROUND, OPT_WRITEABLE, OPT_WORD_0A, OPT_WORD_1A, OPT_WORD_1D, OPT_WORD_1E:
            payload_len = 3'd2;
         OPT_DWORD_16, OPT_DWORD_19:
            payload_len = 3'd4;
         default:
            payload_len = 3'd0;
      endcase
   endfunction

   function automatic logic code_known(input logic [7:0] c);
      code_known = (c <= OPT_LAST);
   endfunction

   // Fit a count value to the result port width.
   function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_WIDTH-1:0] x);
      logic [COUNT_WIDTH+OUT_CNT_W-1:0] w;
      w = {{OUT_CNT_W{1'b0}}, x};
      cnt_out = w[OUT_CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/item_record_stream_parser_core.sv
// Top level of the item record stream parser.
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_ready  | data_byte, start_of_file
//   rsp      | out       | rsp_valid/rsp_ready  | event, ids, option words, sprite data
//
// One byte word is parsed per cycle unless the result side stalls: input register, one pass
// of the parser state machine with its 24x8 count multiply, then the result register.
// A result passes from the input register through the parser into the result register.
// Synchronous reset returns the parser to the file header, record 100.
// When rsp_ready is low with a result held, the result register holds and the input register backs up.
`default_nettype none
`include "assert_macros.svh"

module item_record_stream_parser_core
   import isp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_file,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [15:0]      rsp_item_id,
   output logic [7:0]       rsp_code,
   output logic [31:0]      rsp_value,
   output logic [15:0]      rsp_value_high,
   output logic [2:0]       rsp_item_group,
   output logic [23:0]      rsp_sprite_count,
   output logic [23:0]      rsp_sprite_index,
   output logic [15:0]      rsp_sprite_id,
   output logic             rsp_sprite_keep,
   output logic             rsp_last_of_item
);

   req_type req;
   req_type in_word;
   logic    in_valid;
   logic    out_free;
   logic    step;
   logic    res_valid;
   logic    res_load;
   rsp_type res;
   rsp_type rsp;

   assign req.data_byte     = req_data_byte;
   assign req.start_of_file = req_start_of_file;

   // Parse the held byte whenever the result slot can take its outcome.
   assign step     = in_valid && out_free;
   assign res_load = step && res_valid;

   isp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .step      (step),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   isp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (in_word),
      .res_valid (res_valid),
      .res       (res)
   );

   isp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_event_res    = rsp.event_res;
   assign rsp_item_id      = rsp.item_id;
   assign rsp_code         = rsp.code;
   assign rsp_value        = rsp.value;
   assign rsp_value_high   = rsp.value_high;
   assign rsp_item_group   = rsp.item_group;
   assign rsp_sprite_count = rsp.sprite_count;
   assign rsp_sprite_index = rsp.sprite_index;
   assign rsp_sprite_id    = rsp.sprite_id;
   assign rsp_sprite_keep  = rsp.sprite_keep;
   assign rsp_last_of_item = rsp.last_of_item;

   `ISP_ASSERT(a_error_ends_item, (rsp_valid && rsp_event_res == EV_ERROR) |-> rsp_last_of_item, "error result without end of item")
   `ISP_ASSERT(a_sprite_in_range, (rsp_valid && rsp_event_res == EV_SPRITE) |-> (rsp_sprite_index < rsp_sprite_count), "sprite index beyond count")
   `ISP_ASSERT(a_no_overwrite, res_load |-> !(rsp_valid && !rsp_ready), "result overwritten while stalled")
   `ISP_ASSERT_NEXT(a_accept_fills, req_valid && req_ready, in_valid, "accepted word not held")

endmodule

`default_nettype wire

>>> sv/isp_in_reg.sv
// Input register of the stream parser: captures one word and holds it until parsed.
`default_nettype none

module isp_in_reg
   import isp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   input  wire logic    step,
   output logic         in_valid,
   output req_type      in_word
);

   logic    valid_ff, valid_in;
   req_type word_ff, word_in;

   // Take a new word when empty or when the held one is parsed this cycle.
   assign req_ready = !valid_ff || step;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         word_in  = req;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

`default_nettype wire

>>> sv/isp_parse.sv
// Parser state machine: consumes one file byte per step and forms at most one result.
`default_nettype none

module isp_parse
   import isp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   output logic         res_valid,
   output rsp_type      res
);

   typedef enum logic [2:0] {
      PH_HDR,
      PH_OPT,
      PH_PAY,
      PH_GEOM,
      PH_SKIP,
      PH_SPR,
      PH_HALT
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [3:0]             count_ff, count_in;
   logic [31:0]            version_ff, version_in;
   logic [15:0]            max_item_ff, max_item_in;
   logic [15:0]            item_ff, item_in;
   logic [7:0]             opcode_ff, opcode_in;
   logic [31:0]            payload_ff, payload_in;
   group_type              group_ff, group_in;
   logic [23:0]            keep_ff, keep_in;
   logic [COUNT_WIDTH-1:0] product_ff, product_in;
   logic                   ovf_ff, ovf_in;
   logic                   big_ff, big_in;
   logic [COUNT_WIDTH-1:0] sprite_ff, sprite_in;
   logic [7:0]             low_ff, low_in;

   // Start of file forces the reset view of the state.
   phase_type              ph;
   logic [3:0]             cnt;
   logic [7:0]             b;
   logic [15:0]            item_next;
   logic                   start_rec;
   logic [2:0]             len;
   logic [COUNT_WIDTH+7:0] prod_full;
   logic                   prod_sat;
   logic [31:0]            keep_full;
   logic [COUNT_WIDTH+23:0] sprite_w, keep_w;

   always_comb begin
      b           = req.data_byte;
      ph          = req.start_of_file ? PH_HDR : phase_ff;
      cnt         = req.start_of_file ? 4'd0 : count_ff;
      version_in  = req.start_of_file ? 32'd0 : version_ff;
      max_item_in = req.start_of_file ? 16'd0 : max_item_ff;
      item_in     = req.start_of_file ? FIRST_ITEM : item_ff;
      group_in    = req.start_of_file ? GRP_NONE : group_ff;
      phase_in    = ph;
      count_in    = cnt;
      opcode_in   = opcode_ff;
      payload_in  = payload_ff;
      keep_in     = keep_ff;
      product_in  = product_ff;
      ovf_in      = ovf_ff;
      big_in      = big_ff;
      sprite_in   = sprite_ff;
      low_in      = low_ff;
      item_next   = item_in;
      start_rec   = 1'b0;
      len         = payload_len(b);

      // One 24x8 multiply for the count, one for the keep limit.
      prod_full = {8'd0, product_ff} * {{COUNT_WIDTH{1'b0}}, b};
      prod_sat  = |prod_full[COUNT_WIDTH+7:COUNT_WIDTH];
      keep_full = {8'd0, keep_ff} * {24'd0, b};
      sprite_w  = {24'd0, sprite_ff};
      keep_w    = {{COUNT_WIDTH{1'b0}}, keep_ff};

      res_valid        = 1'b0;
      res              = '0;
      res.item_id      = item_in;
      res.item_group   = group_in;

      unique case (ph)
         PH_HDR: begin
            if (cnt < 4'd4) begin
               version_in[8*cnt[1:0] +: 8] = b;
            end else if (cnt == 4'd4) begin
               max_item_in[7:0] = b;
            end else if (cnt == 4'd5) begin
               max_item_in[15:8] = b;
            end
            count_in = cnt + 4'd1;
            if (count_in == HEADER_BYTES) begin
               res_valid        = 1'b1;
               res.event_res    = EV_HEADER;
               res.value        = version_in;
               res.value_high   = max_item_in;
               res.item_group   = GRP_NONE;
               start_rec        = 1'b1;
            end
         end

         PH_OPT: begin
            if (b == OPT_END) begin
               phase_in = PH_GEOM;
               count_in = 4'd0;
            end else if (!code_known(b)) begin
               res_valid        = 1'b1;
               res.event_res    = EV_ERROR;
               res.code         = b;
               res.last_of_item = 1'b1;
               phase_in         = PH_HALT;
            end else begin
               opcode_in  = b;
               payload_in = 32'd0;
               case (b)
                  OPT_GROUND:    group_in = GRP_GROUND;
                  OPT_CONTAINER: group_in = GRP_CONTAINER;
                  OPT_WRITEABLE: group_in = GRP_WRITEABLE;
                  OPT_FLUID:     group_in = GRP_FLUID;
                  OPT_SPLASH:    group_in = GRP_SPLASH;
                  default:       group_in = group_ff;
               endcase
               res.item_group = group_in;
               if (len == 3'd0) begin
                  res_valid     = 1'b1;
                  res.event_res = EV_OPTION;
                  res.code      = b;
               end else begin
                  count_in = 4'd0;
                  phase_in = PH_PAY;
               end
            end
         end

         PH_PAY: begin
            payload_in[8*cnt[1:0] +: 8] = b;
            count_in = cnt + 4'd1;
            if (count_in >= {1'b0, payload_len(opcode_ff)}) begin
               res_valid      = 1'b1;
               res.event_res  = EV_OPTION;
               res.code       = opcode_ff;
               res.value      = {16'd0, payload_in[15:0]};
               res.value_high = payload_in[31:16];
               phase_in       = PH_OPT;
               count_in       = 4'd0;
            end
         end

         PH_SKIP: begin
            phase_in = PH_GEOM;
         end

         PH_GEOM: begin
            if (cnt == 4'd0) begin
               product_in = {{(COUNT_WIDTH-8){1'b0}}, b};
               keep_in    = {16'd0, b};
               big_in     = (b > 8'd1);
            end else begin
               product_in = prod_sat ? COUNT_MAX : prod_full[COUNT_WIDTH-1:0];
               ovf_in     = ovf_ff || prod_sat;
               if (cnt <= 4'd2) begin
                  keep_in = keep_full[23:0];
               end
            end
            if (cnt == 4'd1 && b > 8'd1) begin
               big_in = 1'b1;
            end
            count_in = cnt + 4'd1;
            if (count_in == 4'd2 && big_in) begin
               phase_in = PH_SKIP;
            end
            if (count_in == GEOM_BYTES) begin
               res_valid = 1'b1;
               if (ovf_in) begin
                  res.event_res    = EV_ERROR;
                  res.code         = ERR_COUNT_OVERFLOW;
                  res.last_of_item = 1'b1;
                  phase_in         = PH_HALT;
               end else begin
                  res.event_res    = EV_GEOM;
                  res.sprite_count = cnt_out(product_in);
                  if (product_in == '0) begin
                     res.last_of_item = 1'b1;
                     item_next        = item_in + 16'd1;
                     start_rec        = 1'b1;
                  end else begin
                     phase_in  = PH_SPR;
                     count_in  = 4'd0;
                     sprite_in = '0;
                  end
               end
            end
         end

         PH_SPR: begin
            if (cnt == 4'd0) begin
               low_in   = b;
               count_in = 4'd1;
            end else begin
               count_in         = 4'd0;
               res_valid        = 1'b1;
               res.event_res    = EV_SPRITE;
               res.sprite_count = cnt_out(product_ff);
               res.sprite_index = cnt_out(sprite_ff);
               res.sprite_id    = {b, low_ff};
               res.sprite_keep  = (sprite_w < keep_w) || (group_ff == GRP_FLUID);
               sprite_in        = sprite_ff + 1'b1;
               if (sprite_in >= product_ff) begin
                  res.last_of_item = 1'b1;
                  item_next        = item_in + 16'd1;
                  start_rec        = 1'b1;
               end
            end
         end

         PH_HALT: begin
            phase_in = PH_HALT;
         end

         default: begin
            phase_in = PH_HALT;
         end
      endcase

      // Open the next record, or halt past the signed maximum id.
      item_in = item_next;
      if (start_rec) begin
         if ($signed({1'b0, item_next}) > $signed({max_item_in[15], max_item_in})) begin
            phase_in = PH_HALT;
         end else begin
            phase_in   = PH_OPT;
            count_in   = 4'd0;
            opcode_in  = 8'd0;
            payload_in = 32'd0;
            group_in   = GRP_NONE;
            keep_in    = 24'd0;
            product_in = '0;
            ovf_in     = 1'b0;
            big_in     = 1'b0;
            sprite_in  = '0;
            low_in     = 8'd0;
         end
      end
   end

   // Hold state between steps; advance on each parsed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         count_ff <= 4'd0;
         item_ff  <= FIRST_ITEM;
         group_ff <= GRP_NONE;
         ovf_ff   <= 1'b0;
         big_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         item_ff  <= item_in;
         group_ff <= group_in;
         ovf_ff   <= ovf_in;
         big_ff   <= big_in;
      end
      if (step) begin
         version_ff  <= version_in;
         max_item_ff <= max_item_in;
         opcode_ff   <= opcode_in;
         payload_ff  <= payload_in;
         keep_ff     <= keep_in;
         product_ff  <= product_in;
         sprite_ff   <= sprite_in;
         low_ff      <= low_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/isp_out_reg.sv
// Result register of the stream parser: holds one result word until taken.
`default_nettype none

module isp_out_reg
   import isp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type res,
   output logic         out_free,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   logic    valid_ff, valid_in;
   rsp_type word_ff, word_in;

   // Free when empty or drained in this cycle.
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = res;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = word_ff;

endmodule

`default_nettype wire

>>> tb/tb_item_record_stream_parser_core.sv
// Self-checking testbench for the item record stream parser core.
`timescale 1ns / 1ps

module tb_item_record_stream_parser_core
   import isp_pkg::*;
();

   localparam int WORD_TARGET  = 1900;
   localparam int CALM_TAIL    = 200;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_MAX   = 10;
   localparam int DIR_COUNT    = 25;

   localparam logic [7:0] GROUP_CODES [5] = '{OPT_GROUND, OPT_CONTAINER, OPT_WRITEABLE,
                                              OPT_FLUID, OPT_SPLASH};
   localparam logic [7:0] WORD_CODES [8] = '{OPT_GROUND, OPT_WRITEABLE, OPT_WORD_0A,
                                             OPT_DWORD_16, OPT_DWORD_19, OPT_WORD_1A,
                                             OPT_WORD_1D, OPT_WORD_1E};

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_OPTIONS,
      PH_PAYLOAD,
      PH_GEOMETRY,
      PH_SKIP,
      PH_SPRITES,
      PH_HALTED
   } parse_phase_type;

   // One directed word; typed rows carry the result fields read straight off the format.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        sof;
      logic        typed;
      event_type   ev;
      logic [7:0]  code;
      logic [31:0] value;
      logic [15:0] value_high;
      logic        last;
   } dir_row_type;

   // Header with extreme version and max id, a ground option with full payload,
   // then a geometry whose count just overflows, and one word while halted.
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{8'hFF, 1'b1, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h7F, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b1, EV_HEADER, 8'h00, 32'hFFFF_FFFF, 16'h7FFF, 1'b0},
      '{OPT_GROUND, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, EV_OPTION, OPT_GROUND, 32'h0000_FFFF, 16'h0000, 1'b0},
      '{OPT_END, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h02, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h01, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h01, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0},
      '{8'h01, 1'b0, 1'b1, EV_ERROR, ERR_COUNT_OVERFLOW, 32'h0, 16'h0, 1'b1},
      '{8'h3C, 1'b0, 1'b0, EV_HEADER, 8'h00, 32'h0, 16'h0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [15:0] rsp_item_id;
   logic [7:0]  rsp_code;
   logic [31:0] rsp_value;
   logic [15:0] rsp_value_high;
   logic [2:0]  rsp_item_group;
   logic [23:0] rsp_sprite_count;
   logic [23:0] rsp_sprite_index;
   logic [15:0] rsp_sprite_id;
   logic        rsp_sprite_keep;
   logic        rsp_last_of_item;

   item_record_stream_parser_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state as the stream has been read so far.
   parse_phase_type        ph;
   int                     pos;
   logic [31:0]            ver_acc;
   logic [15:0]            max_id;
   logic [15:0]            rec_id;
   logic [7:0]             opt_code;
   logic [31:0]            opt_bytes;
   group_type              grp;
   logic [23:0]            keep_lim;
   logic [COUNT_WIDTH-1:0] spr_total;
   logic                   spr_ovf;
   logic                   wide_item;
   logic [COUNT_WIDTH-1:0] spr_idx;
   logic [7:0]             id_low;

   rsp_type     parsed_results [$];
   int          fails = 0;
   int          cycles = 0;
   int          stall_left = 0;
   bit          bursty = 1'b1;
   logic [15:0] file_max = FIRST_ITEM;
   bit          big_geom = 1'b0;

   function automatic void parser_clear();
      ph        = PH_HEADER;
      pos       = 0;
      ver_acc   = '0;
      max_id    = '0;
      rec_id    = FIRST_ITEM;
      opt_code  = '0;
      opt_bytes = '0;
      grp       = GRP_NONE;
      keep_lim  = '0;
      spr_total = '0;
      spr_ovf   = 1'b0;
      wide_item = 1'b0;
      spr_idx   = '0;
      id_low    = '0;
   endfunction

   // Queue a result word at the back of the expected list.
   function automatic void expect_result(input rsp_type x);
      parsed_results.insert(parsed_results.size(), x);
   endfunction

   // Begin the record rec_id, or halt once it passes the signed max id.
   function automatic void open_record();
      int top;
      top = int'($signed(max_id));
      if (int'(rec_id) > top) begin
         ph = PH_HALTED;
      end else begin
         ph        = PH_OPTIONS;
         pos       = 0;
         opt_code  = '0;
         opt_bytes = '0;
         grp       = GRP_NONE;
         keep_lim  = '0;
         spr_total = '0;
         spr_ovf   = 1'b0;
         wide_item = 1'b0;
         spr_idx   = '0;
         id_low    = '0;
      end
   endfunction

   // Payload bytes behind an option code; -1 marks an unknown code.
   function automatic int payload_size(logic [7:0] c);
      case (c) inside
         OPT_GROUND, OPT_WRITEABLE, OPT_WORD_0A, OPT_WORD_1A, OPT_WORD_1D, OPT_WORD_1E:
            return 2;
         OPT_DWORD_16, OPT_DWORD_19:
            return 4;
         default:
            return (c <= OPT_LAST) ? 0 : -1;
      endcase
   endfunction

   // Advance the parser state by one word and work out the result it causes.
   function automatic void parse_byte(input logic [7:0] b, input logic sof,
                                      output logic hit, output rsp_type r);
      int                     n;
      logic [COUNT_WIDTH+7:0] prod;
      if (sof) parser_clear();
      hit = 1'b0;
      r = '0;
      r.item_id = rec_id;
      r.item_group = grp;
      case (ph)
         PH_HEADER: begin
            if (pos < 4) ver_acc |= 32'(b) << (8 * pos);
            else if (pos == 4) max_id[7:0] = b;
            else if (pos == 5) max_id[15:8] = b;
            pos++;
            if (pos == int'(HEADER_BYTES)) begin
               hit = 1'b1;
               r.event_res = EV_HEADER;
               r.value = ver_acc;
               r.value_high = max_id;
               r.item_group = GRP_NONE;
               open_record();
            end
         end
         PH_OPTIONS: begin
            n = payload_size(b);
            if (b == OPT_END) begin
               ph = PH_GEOMETRY;
               pos = 0;
            end else if (n < 0) begin
               hit = 1'b1;
               r.event_res = EV_ERROR;
               r.code = b;
               r.last_of_item = 1'b1;
               ph = PH_HALTED;
            end else begin
               opt_code = b;
               opt_bytes = '0;
               case (b)
                  OPT_GROUND:    grp = GRP_GROUND;
                  OPT_CONTAINER: grp = GRP_CONTAINER;
                  OPT_WRITEABLE: grp = GRP_WRITEABLE;
                  OPT_FLUID:     grp = GRP_FLUID;
                  OPT_SPLASH:    grp = GRP_SPLASH;
                  default: ;
               endcase
               r.item_group = grp;
               if (n == 0) begin
                  hit = 1'b1;
                  r.event_res = EV_OPTION;
                  r.code = b;
               end else begin
                  pos = 0;
                  ph = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            opt_bytes |= 32'(b) << (8 * (pos % 4));
            pos++;
            if (pos >= payload_size(opt_code)) begin
               hit = 1'b1;
               r.event_res = EV_OPTION;
               r.code = opt_code;
               r.value = {16'h0000, opt_bytes[15:0]};
               r.value_high = opt_bytes[31:16];
               ph = PH_OPTIONS;
               pos = 0;
            end
         end
         PH_SKIP: begin
            ph = PH_GEOMETRY;
         end
         PH_GEOMETRY: begin
            if (pos == 0) begin
               spr_total = COUNT_WIDTH'(b);
               keep_lim = 24'(b);
               wide_item = (b > 8'd1);
            end else begin
               prod = {8'd0, spr_total} * (COUNT_WIDTH+8)'(b);
               if (prod > COUNT_MAX) begin
                  spr_total = COUNT_MAX;
                  spr_ovf = 1'b1;
               end else begin
                  spr_total = prod[COUNT_WIDTH-1:0];
               end
               if (pos <= 2) keep_lim = keep_lim * 24'(b);
            end
            if (pos == 1 && b > 8'd1) wide_item = 1'b1;
            pos++;
            if (pos == 2 && wide_item) ph = PH_SKIP;
            if (pos == int'(GEOM_BYTES)) begin
               hit = 1'b1;
               if (spr_ovf) begin
                  r.event_res = EV_ERROR;
                  r.code = ERR_COUNT_OVERFLOW;
                  r.last_of_item = 1'b1;
                  ph = PH_HALTED;
               end else begin
                  r.event_res = EV_GEOM;
                  r.sprite_count = cnt_out(spr_total);
                  if (spr_total == '0) begin
                     r.last_of_item = 1'b1;
                     rec_id++;
                     open_record();
                  end else begin
                     ph = PH_SPRITES;
                     pos = 0;
                     spr_idx = '0;
                  end
               end
            end
         end
         PH_SPRITES: begin
            if (pos == 0) begin
               id_low = b;
               pos = 1;
            end else begin
               pos = 0;
               hit = 1'b1;
               r.event_res = EV_SPRITE;
               r.sprite_count = cnt_out(spr_total);
               r.sprite_index = cnt_out(spr_idx);
               r.sprite_id = {b, id_low};
               r.sprite_keep = (spr_idx < keep_lim) || (grp == GRP_FLUID);
               spr_idx++;
               if (spr_idx >= spr_total) begin
                  r.last_of_item = 1'b1;
                  rec_id++;
                  open_record();
               end
            end
         end
         default: begin
            ph = PH_HALTED;
         end
      endcase
   endfunction

   // Pick the next word: mostly well-formed files with random content, some noise.
   function automatic void choose_word(output logic [7:0] b, output logic sof);
      int pick;
      sof = 1'b0;
      b = 8'($urandom);
      if (ph == PH_HALTED ? $urandom_range(0, 1) == 0 : $urandom_range(0, 299) == 0) begin
         sof = 1'b1;
         file_max = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'(int'(FIRST_ITEM) + $urandom_range(0, 5));
         return;
      end
      pick = $urandom_range(0, 99);
      case (ph)
         PH_HEADER: begin
            if (pos == 4) b = file_max[7:0];
            else if (pos == 5) b = file_max[15:8];
         end
         PH_OPTIONS: begin
            if (pick < 30) b = OPT_END;
            else if (pick < 33) b = 8'($urandom_range(int'(OPT_LAST) + 1, int'(OPT_END) - 1));
            else if (pick < 55) b = GROUP_CODES[$urandom_range(0, 4)];
            else if (pick < 70) b = WORD_CODES[$urandom_range(0, 7)];
            else b = 8'($urandom_range(0, int'(OPT_LAST)));
         end
         PH_GEOMETRY: begin
            // Keep counts small; now and then force a count overflow.
            if (pos == 0) big_geom = ($urandom_range(0, 39) == 0);
            if (big_geom) b = 8'($urandom_range(128, 255));
            else if (pick < 4) b = 8'd0;
            else if (pick < 65) b = 8'd1;
            else if (pick < 92) b = 8'd2;
            else if (pick < 99) b = 8'd3;
            else b = 8'($urandom_range(4, 16));
         end
         default: ;
      endcase
   endfunction

   // Present one word, with a random gap in front, and hold it until accepted.
   task automatic send_word(input logic [7:0] b, input logic sof);
      if (bursty && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_of_file <= sof;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic string show(rsp_type x);
      return $sformatf({"ev=%0d item=%0d code=%h val=%h hi=%h grp=%0d cnt=%0d idx=%0d ",
                        "id=%h keep=%b last=%b"},
                       x.event_res, x.item_id, x.code, x.value, x.value_high, x.item_group,
                       x.sprite_count, x.sprite_index, x.sprite_id, x.sprite_keep,
                       x.last_of_item);
   endfunction

   // Stall the result side in short random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted result word with the oldest parsed result.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      string   diff;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_type'({rsp_event_res, rsp_item_id, rsp_code, rsp_value, rsp_value_high,
                          rsp_item_group, rsp_sprite_count, rsp_sprite_index, rsp_sprite_id,
                          rsp_sprite_keep, rsp_last_of_item});
         if (parsed_results.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX) $display("unexpected result word: %s", show(got));
         end else begin
            want = parsed_results.pop_front();
            diff = "";
            if (got.event_res !== want.event_res) diff = {diff, " event_res"};
            if (got.item_id !== want.item_id) diff = {diff, " item_id"};
            if (got.code !== want.code) diff = {diff, " code"};
            if (got.value !== want.value) diff = {diff, " value"};
            if (got.value_high !== want.value_high) diff = {diff, " value_high"};
            if (got.item_group !== want.item_group) diff = {diff, " item_group"};
            if (got.sprite_count !== want.sprite_count) diff = {diff, " sprite_count"};
            if (got.sprite_index !== want.sprite_index) diff = {diff, " sprite_index"};
            if (got.sprite_id !== want.sprite_id) diff = {diff, " sprite_id"};
            if (got.sprite_keep !== want.sprite_keep) diff = {diff, " sprite_keep"};
            if (got.last_of_item !== want.last_of_item) diff = {diff, " last_of_item"};
            if (diff != "") begin
               fails++;
               if (fails <= REPORT_MAX) begin
                  $display("mismatch in%s", diff);
                  $display("  expected %s", show(want));
                  $display("  actual   %s", show(got));
               end
            end
         end
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic       hit;
      logic       sof;
      logic       counted;
      logic [7:0] b;
      rsp_type    r;
      int         sent;
      parser_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; typed rows pin the fields they carry.
      for (int i = 0; i < DIR_COUNT; i++) begin
         parse_byte(DIR_ROWS[i].data_byte, DIR_ROWS[i].sof, hit, r);
         if (DIR_ROWS[i].typed) begin
            r.event_res = DIR_ROWS[i].ev;
            r.code = DIR_ROWS[i].code;
            r.value = DIR_ROWS[i].value;
            r.value_high = DIR_ROWS[i].value_high;
            r.last_of_item = DIR_ROWS[i].last;
         end
         if (hit || DIR_ROWS[i].typed) expect_result(r);
         send_word(DIR_ROWS[i].data_byte, DIR_ROWS[i].sof);
      end

      // Random files; words sent while halted do not count.
      sent = 0;
      while (sent < WORD_TARGET) begin
         if (sent >= WORD_TARGET - CALM_TAIL) bursty = 1'b0;
         else if (sent % 64 == 0) bursty = ($urandom_range(0, 3) != 0);
         choose_word(b, sof);
         counted = (ph != PH_HALTED) || sof;
         parse_byte(b, sof, hit, r);
         if (hit) expect_result(r);
         send_word(b, sof);
         if (counted) sent++;
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays.
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fails += parsed_results.size();
      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/isp_pkg.sv
sv/isp_in_reg.sv
sv/isp_parse.sv
sv/isp_out_reg.sv
sv/item_record_stream_parser_core.sv
tb/tb_item_record_stream_parser_core.sv
